[design/pit_pkg.sv]
// Shared types and constants for the point-in-tetrahedron test block.
`timescale 1ns / 1ps
`default_nettype none

package pit_pkg;

	// Register port geometry: 64-bit data, registers at 8-byte strides.
	localparam int PDATA_W = 64;
	localparam int PADDR_W = 6;
	localparam int REG_IDX_W = 3;

	typedef logic [PDATA_W-1:0] pit_word_t;

	// Register indexes in address order.
	typedef enum logic [REG_IDX_W-1:0] {
		REG_VERTEX_ZERO,
		REG_VERTEX_ONE,
		REG_VERTEX_TWO,
		REG_VERTEX_THREE,
		REG_FIX_ORDER
	} pit_reg_t;

	// Current register contents as seen by the datapath.
	typedef struct packed {
		pit_word_t vertex_zero;
		pit_word_t vertex_one;
		pit_word_t vertex_two;
		pit_word_t vertex_three;
		logic      fix_order;
	} pit_cfg_t;

endpackage

`default_nettype wire

[design/pit_point_if.sv]
// Query point channel: valid/ready handshake carrying one 3-D point per beat.
`timescale 1ns / 1ps
`default_nettype none

interface pit_point_if #(
	parameter int COORD_WIDTH = 16
) ();
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] px;
	logic signed [COORD_WIDTH-1:0] py;
	logic signed [COORD_WIDTH-1:0] pz;

	modport source (output valid, output px, output py, output pz, input ready);
	modport sink (input valid, input px, input py, input pz, output ready);
endinterface

`default_nettype wire

[design/pit_result_if.sv]
// Result channel: valid/ready handshake carrying one inside flag per beat.
`timescale 1ns / 1ps
`default_nettype none

interface pit_result_if ();
	logic valid;
	logic ready;
	logic inside_res;

	modport source (output valid, output inside_res, input ready);
	modport sink (input valid, input inside_res, output ready);
endinterface

`default_nettype wire

[design/pit_regs.sv]
// APB-style register file holding the four vertices and the ordering enable.
`timescale 1ns / 1ps
`default_nettype none

module pit_regs import pit_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire pit_word_t          pwdata,
	output pit_word_t               prdata,
	output logic                    pready,
	output pit_cfg_t                cfg
);

	localparam int VTX_W = 3 * COORD_WIDTH;

	pit_cfg_t cfg_q;
	pit_reg_t idx;
	logic     wr_en;

	assign idx    = pit_reg_t'(paddr[PADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; unused upper bits are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_VERTEX_ZERO:  cfg_q.vertex_zero  <= pit_word_t'(pwdata[VTX_W-1:0]);
				REG_VERTEX_ONE:   cfg_q.vertex_one   <= pit_word_t'(pwdata[VTX_W-1:0]);
				REG_VERTEX_TWO:   cfg_q.vertex_two   <= pit_word_t'(pwdata[VTX_W-1:0]);
				REG_VERTEX_THREE: cfg_q.vertex_three <= pit_word_t'(pwdata[VTX_W-1:0]);
				REG_FIX_ORDER:    cfg_q.fix_order    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_VERTEX_ZERO:  prdata = cfg_q.vertex_zero;
			REG_VERTEX_ONE:   prdata = cfg_q.vertex_one;
			REG_VERTEX_TWO:   prdata = cfg_q.vertex_two;
			REG_VERTEX_THREE: prdata = cfg_q.vertex_three;
			REG_FIX_ORDER:    prdata = pit_word_t'(cfg_q.fix_order);
			default:          prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[design/pit_core.sv]
// Six-stage half-space datapath: edges, face normals, split dot products, signs, verdict.
`timescale 1ns / 1ps
`default_nettype none

module pit_core import pit_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire pit_cfg_t  cfg,
	pit_point_if.sink      point,
	pit_result_if.source   result
);

	localparam int W   = COORD_WIDTH;
	localparam int EW  = W + 1;              // edge / relative vector
	localparam int PW  = 2 * EW;             // one product in a cross
	localparam int CW  = PW + 1;             // cross product component
	localparam int S   = (CW + 1) / 2;       // split point of a normal
	localparam int LW  = S + 1 + EW;         // low partial product
	localparam int HW  = CW - S + EW;        // high partial product
	localparam int LSW = LW + 2;             // sum of three low parts
	localparam int HSW = HW + 2;             // sum of three high parts
	localparam int DW  = CW + EW + 3;        // full dot product
	localparam int ND  = 6;                  // dot products per point

	typedef logic signed [W-1:0]  cvec_t [3];
	typedef logic signed [EW-1:0] evec_t [3];
	typedef logic signed [CW-1:0] nvec_t [3];

	// One component pair of a cross product, exact
	function automatic logic signed [CW-1:0] xdiff(
		input logic signed [EW-1:0] a1,
		input logic signed [EW-1:0] b2,
		input logic signed [EW-1:0] a2,
		input logic signed [EW-1:0] b1
	);
		logic signed [PW-1:0] m0;
		logic signed [PW-1:0] m1;
		m0 = PW'(a1) * PW'(b2);
		m1 = PW'(a2) * PW'(b1);
		return CW'(m0) - CW'(m1);
	endfunction

	function automatic nvec_t xprod(input evec_t u, input evec_t w);
		nvec_t r;
		r[0] = xdiff(u[1], w[2], u[2], w[1]);
		r[1] = xdiff(u[2], w[0], u[0], w[2]);
		r[2] = xdiff(u[0], w[1], u[1], w[0]);
		return r;
	endfunction

	function automatic evec_t vsub(input cvec_t x, input cvec_t y);
		evec_t r;
		for (int k = 0; k < 3; k++) begin
			r[k] = EW'(x[k]) - EW'(y[k]);
		end
		return r;
	endfunction

	// Stage enables: a stage loads when empty or when its successor moves
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6;

	assign en_s6 = !vld_s6 || result.ready;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;

	assign point.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= point.valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
		end
	end

	// Unpack vertices and the point
	cvec_t v0, v1, v2, v3, pp;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			v0[k] = $signed(cfg.vertex_zero[k*W +: W]);
			v1[k] = $signed(cfg.vertex_one[k*W +: W]);
			v2[k] = $signed(cfg.vertex_two[k*W +: W]);
			v3[k] = $signed(cfg.vertex_three[k*W +: W]);
		end
		pp[0] = point.px;
		pp[1] = point.py;
		pp[2] = point.pz;
	end

	// Stage 1: edges and point offsets for both vertex orders
	evec_t a_s1, b_s1, c_s1, f_s1, g_s1, h_s1, r0_s1, ra_s1, rb_s1;
	logic  fix_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			a_s1   <= vsub(v1, v0);
			b_s1   <= vsub(v2, v0);
			c_s1   <= vsub(v3, v0);
			f_s1   <= vsub(v3, v1);
			g_s1   <= vsub(v3, v2);
			h_s1   <= vsub(v2, v1);
			r0_s1  <= vsub(pp, v0);
			ra_s1  <= vsub(pp, v1);
			rb_s1  <= vsub(pp, v2);
			fix_s1 <= cfg.fix_order;
		end
	end

	// Stage 2: face normals; swapped order reuses them negated.
	// Dots: 0..2 faces of v0, 3 last face, 4 last face swapped, 5 orientation.
	nvec_t nrm_s2 [ND];
	evec_t opd_s2 [ND];
	logic  fix_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			nrm_s2[0] <= xprod(a_s1, b_s1);
			nrm_s2[1] <= xprod(b_s1, c_s1);
			nrm_s2[2] <= xprod(c_s1, a_s1);
			nrm_s2[3] <= xprod(f_s1, h_s1);
			nrm_s2[4] <= xprod(h_s1, g_s1);
			nrm_s2[5] <= xprod(a_s1, b_s1);
			opd_s2[0] <= r0_s1;
			opd_s2[1] <= r0_s1;
			opd_s2[2] <= r0_s1;
			opd_s2[3] <= ra_s1;
			opd_s2[4] <= rb_s1;
			opd_s2[5] <= c_s1;
			fix_s2    <= fix_s1;
		end
	end

	// Stage 3: partial products of each normal component, low part unsigned
	logic signed [LW-1:0] lo_s3 [ND][3];
	logic signed [HW-1:0] hi_s3 [ND][3];
	logic                 fix_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int j = 0; j < ND; j++) begin
				for (int i = 0; i < 3; i++) begin
					lo_s3[j][i] <= LW'($signed({1'b0, nrm_s2[j][i][S-1:0]})) *
						LW'(opd_s2[j][i]);
					hi_s3[j][i] <= HW'($signed(nrm_s2[j][i][CW-1:S])) *
						HW'(opd_s2[j][i]);
				end
			end
			fix_s3 <= fix_s2;
		end
	end

	// Stage 4: sum the three components of each half
	logic signed [LSW-1:0] losum_s4 [ND];
	logic signed [HSW-1:0] hisum_s4 [ND];
	logic                  fix_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			for (int j = 0; j < ND; j++) begin
				losum_s4[j] <= LSW'(lo_s3[j][0]) + LSW'(lo_s3[j][1]) + LSW'(lo_s3[j][2]);
				hisum_s4[j] <= HSW'(hi_s3[j][0]) + HSW'(hi_s3[j][1]) + HSW'(hi_s3[j][2]);
			end
			fix_s4 <= fix_s3;
		end
	end

	// Stage 5: recombine halves and keep only the signs
	logic signed [DW-1:0] full [ND];
	logic [ND-1:0]        pos_s5, neg_s5;
	logic                 fix_s5;

	always_comb begin
		for (int j = 0; j < ND; j++) begin
			full[j] = (DW'(hisum_s4[j]) <<< S) + DW'(losum_s4[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			for (int j = 0; j < ND; j++) begin
				neg_s5[j] <= full[j][DW-1];
				pos_s5[j] <= !full[j][DW-1] && (|full[j]);
			end
			fix_s5 <= fix_s4;
		end
	end

	// Stage 6: verdict; swap when fix_order is set and the first face normal does not face away from v3
	logic swap, outside, inside_s6;

	always_comb begin
		swap = fix_s5 && !neg_s5[5];
		if (swap) begin
			outside = neg_s5[0] || neg_s5[1] || neg_s5[2] || pos_s5[4];
		end else begin
			outside = pos_s5[0] || pos_s5[1] || pos_s5[2] || pos_s5[3];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s6) begin
			inside_s6 <= !outside;
		end
	end

	assign result.valid      = vld_s6;
	assign result.inside_res = inside_s6;

endmodule

`default_nettype wire

[design/point_in_tetrahedron_test.sv]
// Top level of the point-in-tetrahedron test: register file and datapath.
// Throughput: one point per cycle while results are taken; the six-stage pipeline stalls back from the result
//   register, and each stage refills as soon as it is empty.
// Reset: arst_n clears all valid bits and zeroes the registers, so every point is inside.
`timescale 1ns / 1ps
`default_nettype none

module point_in_tetrahedron_test import pit_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire pit_word_t          pwdata,
	output pit_word_t               prdata,
	output logic                    pready,
	pit_point_if.sink               point,
	pit_result_if.source            result
);

	pit_cfg_t cfg;

	pit_regs #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pit_core #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.point  (point),
		.result (result)
	);

endmodule

`default_nettype wire
